FILE: hdl/hhq_pkg.sv
package hhq_pkg;

	// Store geometry
	localparam int MAX_VERTICES = 65536;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int ROW_W        = ADDR_W - 1;
	localparam int BANK_DEPTH   = MAX_VERTICES / 2;

	// Field widths
	localparam int IDX_W    = 16;
	localparam int HGT_W    = 8;
	localparam int COORD_W  = 32;
	localparam int DIM_W    = 11;
	localparam int INV_W    = 24;
	localparam int CFG_IX_W = 3;
	localparam int CFG_D_W  = 32;
	localparam int OUT_W    = 32;

	// Fixed-point layout
	localparam int FRAC_W      = 16;
	localparam int PROD_FRAC_W = 32;
	localparam int PROD_W      = COORD_W - 1 + INV_W;
	localparam int CELL_W      = PROD_W - PROD_FRAC_W;
	localparam int WGT_W       = FRAC_W + 1;
	localparam int ONE         = 1 << FRAC_W;
	localparam int INTERP_W    = HGT_W + FRAC_W;
	localparam int SPROD_W     = INV_W + INTERP_W;
	localparam int SCALED_W    = SPROD_W + 1 - FRAC_W;
	localparam int SUM_AW      = 2 * DIM_W + 1;
	localparam int HSUM_W      = SCALED_W + 2;

	// Register reset values
	localparam logic [INV_W-1:0] INV_RESET   = INV_W'(65536);
	localparam logic [INV_W-1:0] SCALE_RESET = INV_W'(65536);

	typedef enum logic [CFG_IX_W-1:0] {
		REG_GRID_WIDTH    = 3'd0,
		REG_GRID_DEPTH    = 3'd1,
		REG_INV_CELL_X    = 3'd2,
		REG_INV_CELL_Z    = 3'd3,
		REG_HEIGHT_SCALE  = 3'd4,
		REG_HEIGHT_OFFSET = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	// Access bundle toward the banked store
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [HGT_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] a00;
		logic [ADDR_W-1:0] a10;
		logic [ADDR_W-1:0] a01;
		logic [ADDR_W-1:0] a11;
	} store_req_t;

	// Four cell corners, in grid order
	typedef struct packed {
		logic [HGT_W-1:0] h00;
		logic [HGT_W-1:0] h10;
		logic [HGT_W-1:0] h01;
		logic [HGT_W-1:0] h11;
	} corners_t;

endpackage

FILE: hdl/hhq_req_if.sv
interface hhq_req_if;
	logic                                valid;
	logic                                ready;
	logic                                opcode;
	logic [hhq_pkg::IDX_W-1:0]           sample_index;
	logic [hhq_pkg::HGT_W-1:0]           raw_height;
	logic signed [hhq_pkg::COORD_W-1:0]  query_x;
	logic signed [hhq_pkg::COORD_W-1:0]  query_z;

	modport source (output valid, opcode, sample_index, raw_height, query_x, query_z,
		input ready);
	modport sink (input valid, opcode, sample_index, raw_height, query_x, query_z,
		output ready);
endinterface

FILE: hdl/hhq_rsp_if.sv
interface hhq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              inside_res;
	logic signed [hhq_pkg::OUT_W-1:0]  height;

	modport source (output valid, inside_res, height, input ready);
	modport sink (input valid, inside_res, height, output ready);
endinterface

FILE: hdl/hhq_cfg_if.sv
interface hhq_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [hhq_pkg::CFG_IX_W-1:0]   index;
	logic [hhq_pkg::CFG_D_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/hhq_ram.sv
module hhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/hhq_store.sv
module hhq_store (
	input  logic                 clk,
	input  hhq_pkg::store_req_t  req,
	output hhq_pkg::corners_t    corners
);
	import hhq_pkg::*;

	logic             we_even;
	logic             we_odd;
	logic [ROW_W-1:0] wrow;
	logic [HGT_W-1:0] rd_ea;
	logic [HGT_W-1:0] rd_oa;
	logic [HGT_W-1:0] rd_eb;
	logic [HGT_W-1:0] rd_ob;
	logic             swap_a_q;
	logic             swap_b_q;

	// Split writes by address parity; both copies of a bank take the write
	assign we_even = req.we && !req.waddr[0];
	assign we_odd  = req.we && req.waddr[0];
	assign wrow    = req.waddr[ADDR_W-1:1];

	// Copy A serves the row pair a00/a10, copy B serves a01/a11.
	// The even bank always reads the higher address's row, the odd bank the lower's.
	hhq_ram #(.WIDTH(HGT_W), .DEPTH(BANK_DEPTH)) u_ram_ea (
		.clk(clk), .we(we_even), .waddr(wrow), .wdata(req.wdata),
		.re(req.re), .raddr(req.a10[ADDR_W-1:1]), .rdata(rd_ea)
	);

	hhq_ram #(.WIDTH(HGT_W), .DEPTH(BANK_DEPTH)) u_ram_oa (
		.clk(clk), .we(we_odd), .waddr(wrow), .wdata(req.wdata),
		.re(req.re), .raddr(req.a00[ADDR_W-1:1]), .rdata(rd_oa)
	);

	hhq_ram #(.WIDTH(HGT_W), .DEPTH(BANK_DEPTH)) u_ram_eb (
		.clk(clk), .we(we_even), .waddr(wrow), .wdata(req.wdata),
		.re(req.re), .raddr(req.a11[ADDR_W-1:1]), .rdata(rd_eb)
	);

	hhq_ram #(.WIDTH(HGT_W), .DEPTH(BANK_DEPTH)) u_ram_ob (
		.clk(clk), .we(we_odd), .waddr(wrow), .wdata(req.wdata),
		.re(req.re), .raddr(req.a01[ADDR_W-1:1]), .rdata(rd_ob)
	);

	// Track which bank holds the lower corner, aligned with the read data
	always_ff @(posedge clk) begin
		if (req.re) begin
			swap_a_q <= req.a00[0];
			swap_b_q <= req.a01[0];
		end
	end

	// Steer bank data back to corner order
	always_comb begin
		corners.h00 = swap_a_q ? rd_oa : rd_ea;
		corners.h10 = swap_a_q ? rd_ea : rd_oa;
		corners.h01 = swap_b_q ? rd_ob : rd_eb;
		corners.h11 = swap_b_q ? rd_eb : rd_ob;
	end

endmodule

FILE: hdl/heightfield_height_query_core.sv
// Channel | Dir | Payload                                              | Transaction
// req     | in  | opcode, sample_index, raw_height, query_x, query_z   | valid & ready
// rsp     | out | inside_res, height                                   | valid & ready
// cfg     | in  | index, data                                          | valid & ready
//
// One transaction per cycle while the output register is not stalled; a query result
// reaches the output register through the ten-stage pipeline around the store read.
// Sample writes update the banked store in stage three, in order with queries.
// A full output register that is not taken stalls the whole pipeline in place.
// Reset clears the pipeline valid bits and sets configuration to its reset values; store contents stay
// undefined until written, with no clearing pass.
module heightfield_height_query_core (
	input  logic     clk,
	input  logic     arst_n,
	hhq_req_if.sink  req,
	hhq_rsp_if.source rsp,
	hhq_cfg_if.sink  cfg
);
	import hhq_pkg::*;

	// Configuration registers
	logic [DIM_W-1:0]          grid_width_q;
	logic [DIM_W-1:0]          grid_depth_q;
	logic [INV_W-1:0]          inv_cell_x_q;
	logic [INV_W-1:0]          inv_cell_z_q;
	logic [INV_W-1:0]          height_scale_q;
	logic signed [OUT_W-1:0]   height_offset_q;

	logic advance;

	// Stage 1: scaled coordinates
	logic [COORD_W-2:0]        mag_x;
	logic [COORD_W-2:0]        mag_z;
	logic [PROD_W-1:0]         px_d;
	logic [PROD_W-1:0]         pz_d;
	logic                      valid_s1;
	opcode_t                   op_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic [HGT_W-1:0]          raw_s1;
	logic [PROD_W-1:0]         px_s1;
	logic [PROD_W-1:0]         pz_s1;
	logic                      neg_s1;

	// Stage 2: cell and range check
	logic [CELL_W-1:0]         u0;
	logic [CELL_W-1:0]         v0;
	logic                      small_grid;
	logic                      u_over;
	logic                      v_over;
	logic [DIM_W-1:0]          u0n;
	logic                      valid_s2;
	opcode_t                   op_s2;
	logic [IDX_W-1:0]          idx_s2;
	logic [HGT_W-1:0]          raw_s2;
	logic                      inside_s2;
	logic [2*DIM_W-1:0]        v0w_s2;
	logic [DIM_W:0]            u0_s2;
	logic [DIM_W:0]            u0p1_s2;
	logic [DIM_W:0]            u0pw_s2;
	logic [DIM_W:0]            u0pw1_s2;
	logic [FRAC_W-1:0]         fu_s2;
	logic [FRAC_W-1:0]         fv_s2;

	// Stage 3: corner addresses and store access
	logic [SUM_AW-1:0]         a00_d;
	logic [SUM_AW-1:0]         a10_d;
	logic [SUM_AW-1:0]         a01_d;
	logic [SUM_AW-1:0]         a11_d;
	logic                      idx_ok;
	store_req_t                store_req;
	corners_t                  corners;
	logic                      valid_s3;
	opcode_t                   op_s3;
	logic [IDX_W-1:0]          idx_s3;
	logic [HGT_W-1:0]          raw_s3;
	logic                      inside_s3;
	logic [2*DIM_W-1:0]        v0w_s3;
	logic [DIM_W:0]            u0_s3;
	logic [DIM_W:0]            u0p1_s3;
	logic [DIM_W:0]            u0pw_s3;
	logic [DIM_W:0]            u0pw1_s3;
	logic [FRAC_W-1:0]         fu_s3;
	logic [FRAC_W-1:0]         fv_s3;

	// Stage 4: triangle select
	logic                      upper;
	logic                      valid_s4;
	logic                      inside_s4;
	logic [FRAC_W-1:0]         fu_s4;
	logic [FRAC_W-1:0]         fv_s4;

	// Stage 5: weights
	logic                      valid_s5;
	logic                      inside_s5;
	logic [HGT_W-1:0]          h00_s5;
	logic [HGT_W-1:0]          hm_s5;
	logic [HGT_W-1:0]          h11_s5;
	logic [WGT_W-1:0]          w0_s5;
	logic [FRAC_W-1:0]         w1_s5;
	logic [FRAC_W-1:0]         w2_s5;

	// Stage 6: weighted corners
	logic                      valid_s6;
	logic                      inside_s6;
	logic [HGT_W+WGT_W-1:0]    p0_s6;
	logic [INTERP_W-1:0]       p1_s6;
	logic [INTERP_W-1:0]       p2_s6;

	// Stage 7: interpolated raw height
	logic [HGT_W+WGT_W:0]      isum_d;
	logic                      valid_s7;
	logic                      inside_s7;
	logic [INTERP_W-1:0]       interp_s7;

	// Stage 8: scaled product
	logic                      valid_s8;
	logic                      inside_s8;
	logic [SPROD_W-1:0]        sprod_s8;

	// Stage 9: rounded height
	logic [SPROD_W:0]          round_d;
	logic                      valid_s9;
	logic                      inside_s9;
	logic [SCALED_W-1:0]       scaled_s9;

	// Output register
	logic signed [HSUM_W-1:0]  hsum_d;
	logic [OUT_W-1:0]          hsat_d;
	logic                      rsp_valid_q;
	logic                      rsp_inside_q;
	logic [OUT_W-1:0]          rsp_height_q;

	// Configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= '0;
			grid_depth_q    <= '0;
			inv_cell_x_q    <= INV_RESET;
			inv_cell_z_q    <= INV_RESET;
			height_scale_q  <= SCALE_RESET;
			height_offset_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_GRID_WIDTH:    grid_width_q    <= cfg.data[DIM_W-1:0];
				REG_GRID_DEPTH:    grid_depth_q    <= cfg.data[DIM_W-1:0];
				REG_INV_CELL_X:    inv_cell_x_q    <= cfg.data[INV_W-1:0];
				REG_INV_CELL_Z:    inv_cell_z_q    <= cfg.data[INV_W-1:0];
				REG_HEIGHT_SCALE:  height_scale_q  <= cfg.data[INV_W-1:0];
				REG_HEIGHT_OFFSET: height_offset_q <= signed'(cfg.data[OUT_W-1:0]);
				default: ;
			endcase
		end
	end

	// Advance the whole pipeline unless a result waits untaken
	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = advance;

	// Stage 1: multiply magnitudes; a negative coordinate scales to zero
	assign mag_x = req.query_x[COORD_W-1] ? '0 : req.query_x[COORD_W-2:0];
	assign mag_z = req.query_z[COORD_W-1] ? '0 : req.query_z[COORD_W-2:0];
	assign px_d  = PROD_W'(mag_x) * PROD_W'(inv_cell_x_q);
	assign pz_d  = PROD_W'(mag_z) * PROD_W'(inv_cell_z_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1  <= opcode_t'(req.opcode);
			idx_s1 <= req.sample_index;
			raw_s1 <= req.raw_height;
			px_s1  <= px_d;
			pz_s1  <= pz_d;
			neg_s1 <= (req.query_x[COORD_W-1] && (inv_cell_x_q != '0))
				|| (req.query_z[COORD_W-1] && (inv_cell_z_q != '0));
		end
	end

	// Stage 2: split cell and fraction, check grid bounds
	assign u0  = px_s1[PROD_W-1:PROD_FRAC_W];
	assign v0  = pz_s1[PROD_W-1:PROD_FRAC_W];
	assign u0n = u0[DIM_W-1:0];

	assign small_grid = (grid_width_q < DIM_W'(2)) || (grid_depth_q < DIM_W'(2));
	assign u_over = ((CELL_W+1)'(u0) + (CELL_W+1)'(1)) >= (CELL_W+1)'(grid_width_q);
	assign v_over = ((CELL_W+1)'(v0) + (CELL_W+1)'(1)) >= (CELL_W+1)'(grid_depth_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s2     <= op_s1;
			idx_s2    <= idx_s1;
			raw_s2    <= raw_s1;
			inside_s2 <= !neg_s1 && !small_grid && !u_over && !v_over;
			v0w_s2    <= (2*DIM_W)'(v0[DIM_W-1:0]) * (2*DIM_W)'(grid_width_q);
			u0_s2     <= (DIM_W+1)'(u0n);
			u0p1_s2   <= (DIM_W+1)'(u0n) + (DIM_W+1)'(1);
			u0pw_s2   <= (DIM_W+1)'(u0n) + (DIM_W+1)'(grid_width_q);
			u0pw1_s2  <= (DIM_W+1)'(u0n) + (DIM_W+1)'(grid_width_q) + (DIM_W+1)'(1);
			fu_s2     <= px_s1[PROD_FRAC_W-1 -: FRAC_W];
			fv_s2     <= pz_s1[PROD_FRAC_W-1 -: FRAC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s3     <= op_s2;
			idx_s3    <= idx_s2;
			raw_s3    <= raw_s2;
			inside_s3 <= inside_s2;
			v0w_s3    <= v0w_s2;
			u0_s3     <= u0_s2;
			u0p1_s3   <= u0p1_s2;
			u0pw_s3   <= u0pw_s2;
			u0pw1_s3  <= u0pw1_s2;
			fu_s3     <= fu_s2;
			fv_s3     <= fv_s2;
		end
	end

	// Stage 3: form corner addresses; writes and reads share this stage
	assign a00_d  = SUM_AW'(v0w_s3) + SUM_AW'(u0_s3);
	assign a10_d  = SUM_AW'(v0w_s3) + SUM_AW'(u0p1_s3);
	assign a01_d  = SUM_AW'(v0w_s3) + SUM_AW'(u0pw_s3);
	assign a11_d  = SUM_AW'(v0w_s3) + SUM_AW'(u0pw1_s3);
	assign idx_ok = (32'(idx_s3) < 32'(MAX_VERTICES));

	always_comb begin
		store_req.we    = advance && valid_s3 && (op_s3 == OP_WRITE) && idx_ok;
		store_req.waddr = ADDR_W'(idx_s3);
		store_req.wdata = raw_s3;
		store_req.re    = advance;
		store_req.a00   = a00_d[ADDR_W-1:0];
		store_req.a10   = a10_d[ADDR_W-1:0];
		store_req.a01   = a01_d[ADDR_W-1:0];
		store_req.a11   = a11_d[ADDR_W-1:0];
	end

	hhq_store u_store (
		.clk(clk),
		.req(store_req),
		.corners(corners)
	);

	// Drop write transactions here; queries go on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s4 <= valid_s3 && (op_s3 == OP_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inside_s4 <= inside_s3 && (32'(a11_d) < 32'(MAX_VERTICES));
			fu_s4     <= fu_s3;
			fv_s4     <= fv_s3;
		end
	end

	// Stage 4: pick triangle, weights and middle corner
	assign upper = fu_s4 > fv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inside_s5 <= inside_s4;
			h00_s5    <= corners.h00;
			h11_s5    <= corners.h11;
			hm_s5     <= upper ? corners.h10 : corners.h01;
			w0_s5     <= WGT_W'(ONE) - WGT_W'(upper ? fu_s4 : fv_s4);
			w1_s5     <= upper ? (fu_s4 - fv_s4) : (fv_s4 - fu_s4);
			w2_s5     <= upper ? fv_s4 : fu_s4;
		end
	end

	// Stage 5: weight each corner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (advance) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inside_s6 <= inside_s5;
			p0_s6     <= (HGT_W+WGT_W)'(h00_s5) * (HGT_W+WGT_W)'(w0_s5);
			p1_s6     <= INTERP_W'(hm_s5) * INTERP_W'(w1_s5);
			p2_s6     <= INTERP_W'(h11_s5) * INTERP_W'(w2_s5);
		end
	end

	// Stage 6: sum weighted corners; the weights add to one so the sum fits
	assign isum_d = (HGT_W+WGT_W+1)'(p0_s6) + (HGT_W+WGT_W+1)'(p1_s6)
		+ (HGT_W+WGT_W+1)'(p2_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (advance) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inside_s7 <= inside_s6;
			interp_s7 <= isum_d[INTERP_W-1:0];
		end
	end

	// Stage 7: apply vertical scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (advance) begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inside_s8 <= inside_s7;
			sprod_s8  <= SPROD_W'(height_scale_q) * SPROD_W'(interp_s7);
		end
	end

	// Stage 8: round half up back to 16 fraction bits, unsigned Q17.16
	assign round_d = (SPROD_W+1)'(sprod_s8) + (SPROD_W+1)'(ONE / 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (advance) begin
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inside_s9 <= inside_s8;
			scaled_s9 <= round_d[SPROD_W:FRAC_W];
		end
	end

	// Stage 9: add offset and saturate to 32 bits
	assign hsum_d = signed'(HSUM_W'(scaled_s9)) + HSUM_W'(height_offset_q);

	always_comb begin
		if (hsum_d[HSUM_W-1:OUT_W-1] == '0 || hsum_d[HSUM_W-1:OUT_W-1] == '1) begin
			hsat_d = hsum_d[OUT_W-1:0];
		end else if (hsum_d[HSUM_W-1]) begin
			hsat_d = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			hsat_d = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_inside_q <= inside_s9;
			rsp_height_q <= inside_s9 ? hsat_d : '0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.inside_res = rsp_inside_q;
	assign rsp.height     = signed'(rsp_height_q);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import hhq_pkg::*;

	localparam longint HEIGHT_MAX  = 64'sd2147483647;
	localparam longint HEIGHT_MIN  = -64'sd2147483648;
	localparam int     SETTLE_CYC  = 16;
	localparam int     HOLD_CYC    = 80;
	localparam int     RANDOM_ITEMS = 700;
	localparam int     MAX_REPORTS = 10;

	typedef struct {
		opcode_t                    op;
		logic [IDX_W-1:0]           idx;
		logic [HGT_W-1:0]           raw;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  z;
	} hf_item_t;

	typedef struct packed {
		logic              in_grid;
		logic [OUT_W-1:0]  height;
	} height_result_t;

	logic clk;
	logic arst_n = 1'b0;

	hhq_req_if req();
	hhq_rsp_if rsp();
	hhq_cfg_if cfg();

	heightfield_height_query_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// Register image as the block should hold it
	logic [DIM_W-1:0]          grid_w   = '0;
	logic [DIM_W-1:0]          grid_d   = '0;
	logic [INV_W-1:0]          inv_x    = INV_RESET;
	logic [INV_W-1:0]          inv_z    = INV_RESET;
	logic [INV_W-1:0]          h_scale  = SCALE_RESET;
	logic signed [CFG_D_W-1:0] h_offset = '0;

	// Predicted store contents and the generator's record of written samples
	logic [HGT_W-1:0] height_mem [0:MAX_VERTICES-1];
	bit               sample_known [0:MAX_VERTICES-1];

	hf_item_t       pending_items [$];
	height_result_t height_expect_q [$];

	hf_item_t next_item;
	logic     req_taken = 1'b0;
	logic     rsp_taken = 1'b0;
	int       req_gap = 0;
	int       rsp_wait = 0;
	int       req_gap_max = 3;
	int       rsp_gap_max = 3;
	bit       hold_ask = 1'b0;
	bit       hold_seen = 1'b0;
	int       hold_left = 0;

	int errors = 0;
	int n_queries = 0;
	int n_inside = 0;
	int n_writes = 0;
	int n_reg_writes = 0;
	int n_holds = 0;
	int queued = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Scale one axis into cell and fraction; reject a negative product
	function automatic bit map_axis(input logic signed [COORD_W-1:0] q,
			input logic [INV_W-1:0] inv, output longint unsigned cell_ix,
			output logic [FRAC_W-1:0] frac);
		logic [63:0] prod;
		if (q < 0 && inv != 0)
			return 1'b0;
		prod = (q < 0) ? 64'd0 : {32'd0, q} * {40'd0, inv};
		cell_ix = prod[63:32];
		frac = prod[31:16];
		return 1'b1;
	endfunction

	// Find the cell under (x, z); false when it lies off the grid or the store
	function automatic bit locate(input logic signed [COORD_W-1:0] qx,
			input logic signed [COORD_W-1:0] qz, output int unsigned a00,
			output logic [FRAC_W-1:0] fu, output logic [FRAC_W-1:0] fv);
		longint unsigned u0, v0;
		if (grid_w < 2 || grid_d < 2)
			return 1'b0;
		if (!map_axis(qx, inv_x, u0, fu))
			return 1'b0;
		if (!map_axis(qz, inv_z, v0, fv))
			return 1'b0;
		if (u0 + 1 >= grid_w || v0 + 1 >= grid_d)
			return 1'b0;
		if ((v0 + 1) * grid_w + u0 + 1 >= MAX_VERTICES)
			return 1'b0;
		a00 = int'(v0 * grid_w + u0);
		return 1'b1;
	endfunction

	function automatic height_result_t predict_height(input logic signed [COORD_W-1:0] qx,
			input logic signed [COORD_W-1:0] qz);
		height_result_t   r;
		int unsigned      a00, w;
		logic [FRAC_W-1:0] fu, fv;
		longint unsigned  fu64, fv64, h00, h10, h01, h11, interp, scaled;
		longint           h;
		r.in_grid = 1'b0;
		r.height = '0;
		if (!locate(qx, qz, a00, fu, fv))
			return r;
		w    = grid_w;
		fu64 = fu;
		fv64 = fv;
		h00  = height_mem[a00];
		h10  = height_mem[a00 + 1];
		h01  = height_mem[a00 + w];
		h11  = height_mem[a00 + w + 1];
		// Pick the triangle by comparing the fractions
		if (fu64 > fv64)
			interp = h00 * (ONE - fu64) + h10 * (fu64 - fv64) + h11 * fv64;
		else
			interp = h00 * (ONE - fv64) + h01 * (fv64 - fu64) + h11 * fu64;
		scaled = (longint'(h_scale) * interp + (1 << (FRAC_W - 1))) >> FRAC_W;
		h = longint'(scaled) + longint'(h_offset);
		if (h > HEIGHT_MAX)
			h = HEIGHT_MAX;
		if (h < HEIGHT_MIN)
			h = HEIGHT_MIN;
		r.in_grid = 1'b1;
		r.height = h[31:0];
		return r;
	endfunction

	task automatic note_failure(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// Driver: present one transaction at a time, with a random gap after each
	always @(negedge clk) begin
		if (arst_n && !(req.valid && !req_taken)) begin
			if (req_taken)
				req_gap = $urandom_range(0, req_gap_max);
			if (req_gap != 0 || pending_items.size() == 0) begin
				req.valid <= 1'b0;
				if (req_gap != 0)
					req_gap--;
			end else begin
				next_item = pending_items.pop_front();
				req.valid        <= 1'b1;
				req.opcode       <= next_item.op;
				req.sample_index <= next_item.idx;
				req.raw_height   <= next_item.raw;
				req.query_x      <= next_item.x;
				req.query_z      <= next_item.z;
			end
		end
	end

	// Predict on every accepted request
	always @(posedge clk) begin
		req_taken <= arst_n && req.valid && req.ready;
		if (arst_n && req.valid && req.ready) begin
			if (req.opcode == OP_WRITE) begin
				height_mem[req.sample_index] = req.raw_height;
				n_writes++;
			end else begin
				height_expect_q.push_back(predict_height(req.query_x, req.query_z));
				n_queries++;
				if (height_expect_q[$].in_grid)
					n_inside++;
			end
		end
	end

	// Long hold of the result channel, counted here
	always @(posedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			hold_left <= HOLD_CYC;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result ready: random wait after each transaction, low during a hold
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_taken)
				rsp_wait = $urandom_range(0, rsp_gap_max);
			if (hold_left != 0 || rsp_wait != 0) begin
				rsp.ready <= 1'b0;
				if (hold_left == 0)
					rsp_wait--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Monitor: compare each result with the oldest expected one
	always @(posedge clk) begin
		height_result_t want;
		rsp_taken <= arst_n && rsp.valid && rsp.ready;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (height_expect_q.size() == 0) begin
				note_failure($sformatf("unexpected result inside=%0b height=%h",
					rsp.inside_res, rsp.height));
			end else begin
				want = height_expect_q.pop_front();
				if (rsp.inside_res !== want.in_grid || rsp.height !== want.height)
					note_failure($sformatf(
						"expected inside=%0b height=%h, got inside=%0b height=%h",
						want.in_grid, want.height, rsp.inside_res, rsp.height));
			end
		end
	end

	task automatic write_reg(input cfg_reg_t ix, input logic [CFG_D_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= ix;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (ix)
			REG_GRID_WIDTH:    grid_w   = val[DIM_W-1:0];
			REG_GRID_DEPTH:    grid_d   = val[DIM_W-1:0];
			REG_INV_CELL_X:    inv_x    = val[INV_W-1:0];
			REG_INV_CELL_Z:    inv_z    = val[INV_W-1:0];
			REG_HEIGHT_SCALE:  h_scale  = val[INV_W-1:0];
			REG_HEIGHT_OFFSET: h_offset = val;
			default: ;
		endcase
		n_reg_writes++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_config(input int gw, input int gd, input logic [INV_W-1:0] ix,
			input logic [INV_W-1:0] iz, input logic [INV_W-1:0] sc,
			input logic [CFG_D_W-1:0] off);
		write_reg(REG_GRID_WIDTH, gw);
		write_reg(REG_GRID_DEPTH, gd);
		write_reg(REG_INV_CELL_X, {8'd0, ix});
		write_reg(REG_INV_CELL_Z, {8'd0, iz});
		write_reg(REG_HEIGHT_SCALE, {8'd0, sc});
		write_reg(REG_HEIGHT_OFFSET, off);
	endtask

	// Wait until every queued transaction is taken and every result is back;
	// sample at the rising edge, where the driver's state is settled
	task automatic drain(input int settle);
		@(posedge clk);
		while (pending_items.size() != 0 || req.valid || height_expect_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic push_item(input opcode_t op, input logic [IDX_W-1:0] idx,
			input logic [HGT_W-1:0] raw, input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] z);
		hf_item_t it;
		it.op  = op;
		it.idx = idx;
		it.raw = raw;
		it.x   = x;
		it.z   = z;
		pending_items.push_back(it);
		if (op == OP_WRITE)
			sample_known[idx] = 1'b1;
		queued++;
	endtask

	task automatic push_write(input int idx, input int raw);
		push_item(OP_WRITE, idx[IDX_W-1:0], raw[HGT_W-1:0], $urandom(), $urandom());
	endtask

	// Queue a query, writing any corner of its cell that was never written
	task automatic push_query(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] z);
		int unsigned       a00, w;
		logic [FRAC_W-1:0] fu, fv;
		int unsigned       corner [4];
		if (locate(x, z, a00, fu, fv)) begin
			w = grid_w;
			corner = '{a00, a00 + 1, a00 + w, a00 + w + 1};
			foreach (corner[k])
				if (!sample_known[corner[k]])
					push_write(corner[k], $urandom_range(0, 255));
		end
		push_item(OP_QUERY, IDX_W'($urandom()), HGT_W'($urandom()), x, z);
	endtask

	// World coordinate whose scaled value lands near the given cell and fraction
	function automatic logic signed [COORD_W-1:0] coord_for(input int cell_ix,
			input logic [FRAC_W-1:0] frac, input logic [INV_W-1:0] inv);
		logic [63:0] target, q;
		if (inv == 0)
			return $urandom();
		target = (64'(cell_ix) << 32) | (64'(frac) << 16)
			| 64'($urandom_range(0, 65535));
		q = (target + inv - 1) / inv;
		if (q > 64'h7FFF_FFFF)
			q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1);
			1: return 1024;
			2: return $urandom_range(2, 1024);
			default: return $urandom_range(2, 12);
		endcase
	endfunction

	function automatic logic [INV_W-1:0] pick_inv();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return INV_W'($urandom());
			3: return 24'd32768;
			4: return 24'd131072;
			5: return INV_RESET;
			default: return INV_W'($urandom_range(16384, 262144));
		endcase
	endfunction

	function automatic logic [INV_W-1:0] pick_scale();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return SCALE_RESET;
			default: return INV_W'($urandom());
		endcase
	endfunction

	function automatic logic [CFG_D_W-1:0] pick_offset();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	// Query aimed inside the grid, mostly within the store's reach
	task automatic push_cell_query();
		int u, v, vmax;
		logic [FRAC_W-1:0] fu, fv;
		u = $urandom_range(0, grid_w - 2);
		vmax = grid_d - 2;
		if ($urandom_range(0, 4) != 0 && 65536 / grid_w - 2 < vmax)
			vmax = 65536 / grid_w - 2;
		v = $urandom_range(0, vmax);
		case ($urandom_range(0, 4))
			0: begin fu = '0; fv = '0; end
			1: begin fu = '1; fv = FRAC_W'($urandom()); end
			2: begin fu = FRAC_W'($urandom()); fv = fu; end
			default: begin fu = FRAC_W'($urandom()); fv = FRAC_W'($urandom()); end
		endcase
		push_query(coord_for(u, fu, inv_x), coord_for(v, fv, inv_z));
	endtask

	function automatic logic signed [COORD_W-1:0] rim_coord(input int dim);
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			4: return (dim - 1) << 16;
			default: return ((dim - 1) << 16) - 1;
		endcase
	endfunction

	task automatic push_random_item();
		case ($urandom_range(0, 9))
			0: push_write($urandom_range(0, 65535), $urandom_range(0, 255));
			1: push_query($urandom(), $urandom());
			2: push_query(rim_coord(grid_w), rim_coord(grid_d));
			default:
				if (grid_w < 2 || grid_d < 2)
					push_query($urandom(), $urandom());
				else
					push_cell_query();
		endcase
	endtask

	initial begin
		byte unsigned sample_vals [9];
		int phase_no, burst, random_base;
		bit pressure;

		sample_vals      = '{0, 255, 17, 200, 64, 128, 3, 250, 90};
		req.valid        = 1'b0;
		req.opcode       = OP_WRITE;
		req.sample_index = '0;
		req.raw_height   = '0;
		req.query_x      = '0;
		req.query_z      = '0;
		rsp.ready        = 1'b0;
		cfg.valid        = 1'b0;
		cfg.index        = REG_GRID_WIDTH;
		cfg.data         = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: empty grid, store extremes
		push_write(65535, 255);
		push_write(0, 0);
		push_query(32'h0000_0000, 32'h0000_0000);
		push_query(32'h7FFF_FFFF, 32'h8000_0000);
		drain(SETTLE_CYC);

		// Three by three grid at unit spacing: both triangles, diagonal, borders
		set_config(3, 3, INV_RESET, INV_RESET, SCALE_RESET, 32'h0);
		foreach (sample_vals[k])
			push_write(k, sample_vals[k]);
		push_query(32'h0000_C000, 32'h0000_4000);
		push_query(32'h0000_4000, 32'h0000_C000);
		push_query(32'h0000_8000, 32'h0000_8000);
		push_query(32'h0001_0000, 32'h0001_0000);
		push_query(32'h0001_FFFF, 32'h0001_FFFF);
		push_query(32'h0002_0000, 32'h0000_0000);
		push_query(32'h0000_0000, 32'h0002_0000);
		push_query(32'hFFFF_FFFF, 32'h0000_0000);
		push_query(32'h8000_0000, 32'h7FFF_FFFF);
		drain(SETTLE_CYC);

		// Zero inverse on x, largest on z, saturate high
		set_config(2, 2, 24'h0, 24'hFF_FFFF, 24'hFF_FFFF, 32'h7FFF_FFFF);
		push_query(32'hFFFB_0000, 32'h0000_0100);
		push_query(32'h0000_0000, 32'h0000_0000);
		drain(SETTLE_CYC);

		// Widest grid: cells near the end of the store, lowest offset
		set_config(1024, 1024, INV_RESET, INV_RESET, SCALE_RESET, 32'h8000_0000);
		push_query(32'h0005_8000, 32'h003E_4000);
		push_query(32'h0005_8000, 32'h003F_8000);
		push_query(32'h03FE_8000, 32'h0000_8000);
		drain(SETTLE_CYC);

		// One column only
		set_config(1, 5, INV_RESET, INV_RESET, SCALE_RESET, 32'h0);
		push_query(32'h0000_0000, 32'h0000_0000);
		drain(SETTLE_CYC);

		// Random settings with mostly well-formed queries
		random_base = queued;
		phase_no = 0;
		while (queued - random_base < RANDOM_ITEMS) begin
			set_config(pick_dim(), pick_dim(), pick_inv(), pick_inv(), pick_scale(),
				pick_offset());
			pressure    = (phase_no % 4 == 1);
			req_gap_max = (pressure || phase_no % 3 == 0) ? 0 : 3;
			rsp_gap_max = (phase_no % 3 == 1) ? 0 : 3;
			burst = $urandom_range(40, 90);
			for (int k = 0; k < burst; k++) begin
				push_random_item();
				// Stall the result side while requests keep coming, then pause
				if (pressure && k == burst / 2) begin
					@(negedge clk);
					hold_ask = ~hold_ask;
					n_holds++;
					drain(0);
				end
			end
			drain(SETTLE_CYC);
			phase_no++;
		end

		if (height_expect_q.size() != 0)
			note_failure($sformatf("%0d results never arrived", height_expect_q.size()));
		$display("Covered %0d queries (%0d inside the grid) and %0d sample writes,",
			n_queries, n_inside, n_writes);
		$display("across %0d register writes and %0d long result stalls.",
			n_reg_writes, n_holds);
		if (errors == 0)
			$display("PASS heightfield_height_query_core");
		else
			$display("FAIL heightfield_height_query_core");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL heightfield_height_query_core");
		$finish;
	end

endmodule

FILE: sim.f
hdl/hhq_pkg.sv
hdl/hhq_req_if.sv
hdl/hhq_rsp_if.sv
hdl/hhq_cfg_if.sv
hdl/hhq_ram.sv
hdl/hhq_store.sv
hdl/heightfield_height_query_core.sv
tb/tb.sv
